[sv/batch_means_std_error_macros.svh]
// Assertion macros shared by the batch-means standard error RTL.
`ifndef BATCH_MEANS_STD_ERROR_MACROS_SVH
`define BATCH_MEANS_STD_ERROR_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define BMSE_ASSERT_HOLDS(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bmse: property violated");

// Condition must hold in the cycle after the trigger.
`define BMSE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bmse: property violated");

`endif

[sv/bmse_pkg.sv]
// Types and constants shared by the batch-means standard error modules.
`default_nettype none

package bmse_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int CFG_W      = 17;
   localparam int SE_W       = 31;
   localparam int DATA_W     = 32;
   localparam int PADDR_W    = 3;
   localparam int ROOT_STEPS = 32;

   localparam logic [SE_W-1:0]  SE_MAX    = 31'h7FFF_FFFF;
   localparam logic [CFG_W-1:0] CFG_RESET = 17'h1_0000;

   // Register index decoded from paddr[2].
   localparam logic REG_SAMPLE_COUNT = 1'b0;

   typedef enum logic [1:0] {
      OP_MUL  = 2'd0,
      OP_DIV  = 2'd1,
      OP_SQRT = 2'd2
   } unit_op_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_cmd_type;

endpackage

`default_nettype wire

[sv/batch_means_std_error.sv]
// Top level of the batch-means Monte Carlo standard error block.
// Usage: program sample_count (n) through the APB-style port at byte address 0,
// then send n signed Q16.16 samples as requests on req_valid/req_ready. The
// batch size is b = floor(sqrt(n)) and the batch count a = floor(n/b); samples
// past a*b are taken and dropped. After the nth request one response carries
// the mean of the batch means and the standard error sqrt(b*e1/((a-1)*n)).
// All arithmetic runs through one bit-serial unit (multiply, divide, square
// root) that retires one bit per cycle. The last sample of a batch adds the
// batch-mean divide, and the first sample of a job adds the work for b and a.
// After the last sample the reduction runs once per batch and then works out
// the mean and the error, and the response then appears on rsp_valid.
// Reset: synchronous and active high; it clears the counters and sets n to
// 65536. The batch-mean store is not cleared; a job reads only the entries it
// wrote. Stalls: the response waits in an output register while rsp_ready is
// low, and new requests are still taken; a second result waits until the
// first is taken. sample_count is sampled at the first request of a job.
`default_nettype none
`include "batch_means_std_error_macros.svh"

module batch_means_std_error #(
   parameter int MAX_SAMPLES = 65536,
   parameter int MAX_BATCHES = 512
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [bmse_pkg::SAMPLE_W-1:0]      req_sample,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [bmse_pkg::SAMPLE_W-1:0]      rsp_overall_mean,
   output logic      [bmse_pkg::SE_W-1:0]          rsp_standard_error,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [bmse_pkg::PADDR_W-1:0]       paddr,
   input  wire logic [bmse_pkg::DATA_W-1:0]        pwdata,
   output logic      [bmse_pkg::DATA_W-1:0]        prdata,
   output logic                                    pready
);

   localparam int X_W    = bmse_pkg::SAMPLE_W;
   localparam int N_W    = $clog2(MAX_SAMPLES + 1);
   localparam int B_W    = (N_W + 1) / 2;
   localparam int A_W    = $clog2(MAX_BATCHES + 1);
   localparam int IDX_W  = $clog2(MAX_BATCHES);
   localparam int ACC_W  = X_W + B_W;
   localparam int SUM_W  = X_W + A_W;
   localparam int Q_W    = 2*X_W - 1 + A_W;
   localparam int WIDE_W = A_W + Q_W + B_W + 2;
   localparam int STEP_W = $clog2(WIDE_W + 1);
   localparam int NX_W   = (N_W > bmse_pkg::CFG_W) ? N_W : bmse_pkg::CFG_W;
   localparam int PB_W   = ACC_W + 2;
   localparam int PM_W   = SUM_W + 2;
   localparam int ROOT_W = 2*bmse_pkg::ROOT_STEPS;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b000_0001,
      S_PROC  = 7'b000_0010,
      S_CHK   = 7'b000_0100,
      S_FADDR = 7'b000_1000,
      S_CALC  = 7'b001_0000,
      S_CWAIT = 7'b010_0000,
      S_EMIT  = 7'b100_0000
   } state_type;

   // Which operation the shared unit runs next.
   typedef enum logic [3:0] {
      P_ISQRT_N = 4'd0,
      P_DIV_NB  = 4'd1,
      P_BMEAN   = 4'd2,
      P_SQUARE  = 4'd3,
      P_MEAN    = 4'd4,
      P_AQ      = 4'd5,
      P_SS      = 4'd6,
      P_X4B     = 4'd7,
      P_DEN1    = 4'd8,
      P_DEN2    = 4'd9,
      P_QUOT    = 4'd10,
      P_ROOT    = 4'd11
   } step_type;

   state_type                    state_ff, state_in;
   step_type                     step_ff, step_in;
   logic [N_W-1:0]               seen_ff, seen_in;
   logic [N_W-1:0]               job_len_ff, job_len_in;
   logic [B_W-1:0]               b_ff, b_in;
   logic [A_W-1:0]               a_ff, a_in;
   logic [ACC_W-1:0]             acc_ff, acc_in;
   logic [B_W-1:0]               wc_ff, wc_in;
   logic [A_W-1:0]               bd_ff, bd_in;
   logic [A_W-1:0]               idx_ff, idx_in;
   logic [X_W-1:0]               x_ff, x_in;
   logic [SUM_W-1:0]             s_ff, s_in;
   logic [Q_W-1:0]               q_ff, q_in;
   logic                         neg_ff, neg_in;
   logic [WIDE_W-1:0]            num_ff, num_in;
   logic [WIDE_W-1:0]            den_ff, den_in;
   logic [X_W-1:0]               mean_ff, mean_in;
   logic [bmse_pkg::SE_W-1:0]    se_ff, se_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [X_W-1:0]               rsp_mean_ff, rsp_mean_in;
   logic [bmse_pkg::SE_W-1:0]    rsp_se_ff, rsp_se_in;
   logic [bmse_pkg::CFG_W-1:0]   cfg_ff;

   bmse_pkg::unit_cmd_type       unit_cmd;
   logic [STEP_W-1:0]            unit_steps;
   logic [WIDE_W-1:0]            unit_opa;
   logic [WIDE_W-1:0]            unit_opb;
   logic                         unit_busy;
   logic [WIDE_W-1:0]            unit_result;

   logic                         ram_wr_en;
   logic [X_W-1:0]               ram_wr_data;
   logic                         ram_rd_en;
   logic [X_W-1:0]               ram_rd_data;

   logic [NX_W-1:0]              cfg_x;
   logic [N_W-1:0]               n_clamped;
   logic [ACC_W-1:0]             acc_sum;
   logic [PB_W-1:0]              p_b, d_b, mag_b;
   logic [PM_W-1:0]              p_m, d_m, mag_m;
   logic [X_W-1:0]               y_mag;
   logic [SUM_W-1:0]             s_mag;
   logic [X_W:0]                 root_inc;
   logic [bmse_pkg::SE_W-1:0]    se_round;
   logic                         cfg_write;

   // Configuration register. Writes land on the access phase; only index 0
   // exists, any other index is dropped.
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == bmse_pkg::REG_SAMPLE_COUNT) ?
                      bmse_pkg::DATA_W'(cfg_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= bmse_pkg::CFG_RESET;
      end else if (cfg_write && (paddr[2] == bmse_pkg::REG_SAMPLE_COUNT)) begin
         cfg_ff <= pwdata[bmse_pkg::CFG_W-1:0];
      end
   end

   // Job length: n clamped to the range the datapath supports.
   always_comb begin
      cfg_x = NX_W'(cfg_ff);
      if (cfg_x < NX_W'(2)) begin
         n_clamped = N_W'(2);
      end else if (cfg_x > NX_W'(MAX_SAMPLES)) begin
         n_clamped = N_W'(MAX_SAMPLES);
      end else begin
         n_clamped = cfg_x[N_W-1:0];
      end
   end

   // Signed floor division is done on magnitudes: for a negative numerator p
   // and divisor d the unit divides (d - 1 - p) and the quotient is negated.
   always_comb begin
      acc_sum = acc_ff + {{B_W{x_ff[X_W-1]}}, x_ff};

      p_b   = {acc_ff[ACC_W-1], acc_ff, 1'b0} + PB_W'(b_ff);
      d_b   = PB_W'({b_ff, 1'b0});
      mag_b = p_b[PB_W-1] ? (d_b - p_b - PB_W'(1)) : p_b;

      p_m   = {s_ff[SUM_W-1], s_ff, 1'b0} + PM_W'(a_ff);
      d_m   = PM_W'({a_ff, 1'b0});
      mag_m = p_m[PM_W-1] ? (d_m - p_m - PM_W'(1)) : p_m;

      y_mag = ram_rd_data[X_W-1] ? (X_W'(0) - ram_rd_data) : ram_rd_data;
      s_mag = s_ff[SUM_W-1] ? (SUM_W'(0) - s_ff) : s_ff;

      // The error is the root rounded half up, saturating at the field maximum.
      root_inc = {1'b0, unit_result[X_W-1:0]} + (X_W+1)'(1);
      se_round = root_inc[X_W] ? bmse_pkg::SE_MAX : root_inc[X_W-1:1];
   end

   assign ram_wr_data = neg_ff ? (X_W'(0) - unit_result[X_W-1:0]) :
                                 unit_result[X_W-1:0];

   // Main sequencer.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      seen_in      = seen_ff;
      job_len_in   = job_len_ff;
      b_in         = b_ff;
      a_in         = a_ff;
      acc_in       = acc_ff;
      wc_in        = wc_ff;
      bd_in        = bd_ff;
      idx_in       = idx_ff;
      x_in         = x_ff;
      s_in         = s_ff;
      q_in         = q_ff;
      neg_in       = neg_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      mean_in      = mean_ff;
      se_in        = se_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_se_in    = rsp_se_ff;

      unit_cmd.start = 1'b0;
      unit_cmd.op    = bmse_pkg::OP_MUL;
      unit_steps     = '0;
      unit_opa       = '0;
      unit_opb       = '0;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in = req_sample;
               if (seen_ff == '0) begin
                  // First request of a job: latch n and work out b and a.
                  job_len_in = n_clamped;
                  acc_in     = '0;
                  wc_in      = '0;
                  bd_in      = '0;
                  step_in    = P_ISQRT_N;
                  state_in   = S_CALC;
               end else begin
                  state_in = S_PROC;
               end
            end
         end

         S_PROC: begin
            seen_in  = seen_ff + N_W'(1);
            state_in = S_CHK;
            if (bd_ff < a_ff) begin
               acc_in = acc_sum;
               if (({1'b0, wc_ff} + (B_W+1)'(1)) >= {1'b0, b_ff}) begin
                  step_in  = P_BMEAN;
                  state_in = S_CALC;
               end else begin
                  wc_in = wc_ff + B_W'(1);
               end
            end
         end

         S_CHK: begin
            if (seen_ff >= job_len_ff) begin
               seen_in  = '0;
               s_in     = '0;
               q_in     = '0;
               idx_in   = '0;
               state_in = S_FADDR;
            end else begin
               state_in = S_IDLE;
            end
         end

         S_FADDR: begin
            ram_rd_en = 1'b1;
            step_in   = P_SQUARE;
            state_in  = S_CALC;
         end

         S_CALC: begin
            unit_cmd.start = 1'b1;
            state_in       = S_CWAIT;
            unique case (step_ff)
               P_ISQRT_N: begin
                  unit_cmd.op = bmse_pkg::OP_SQRT;
                  unit_steps  = STEP_W'(bmse_pkg::ROOT_STEPS);
                  unit_opa    = WIDE_W'(job_len_ff);
               end
               P_DIV_NB: begin
                  unit_cmd.op = bmse_pkg::OP_DIV;
                  unit_steps  = STEP_W'(N_W);
                  unit_opa    = {job_len_ff, {(WIDE_W-N_W){1'b0}}};
                  unit_opb    = WIDE_W'(b_ff);
               end
               P_BMEAN: begin
                  unit_cmd.op = bmse_pkg::OP_DIV;
                  unit_steps  = STEP_W'(PB_W);
                  unit_opa    = {mag_b, {(WIDE_W-PB_W){1'b0}}};
                  unit_opb    = WIDE_W'(d_b);
                  neg_in      = p_b[PB_W-1];
               end
               P_SQUARE: begin
                  unit_cmd.op = bmse_pkg::OP_MUL;
                  unit_steps  = STEP_W'(X_W);
                  unit_opa    = WIDE_W'(y_mag);
                  unit_opb    = WIDE_W'(y_mag);
                  s_in        = s_ff + {{A_W{ram_rd_data[X_W-1]}}, ram_rd_data};
               end
               P_MEAN: begin
                  unit_cmd.op = bmse_pkg::OP_DIV;
                  unit_steps  = STEP_W'(PM_W);
                  unit_opa    = {mag_m, {(WIDE_W-PM_W){1'b0}}};
                  unit_opb    = WIDE_W'(d_m);
                  neg_in      = p_m[PM_W-1];
               end
               P_AQ: begin
                  unit_steps = STEP_W'(A_W);
                  unit_opa   = WIDE_W'(q_ff);
                  unit_opb   = WIDE_W'(a_ff);
               end
               P_SS: begin
                  unit_steps = STEP_W'(SUM_W);
                  unit_opa   = WIDE_W'(s_mag);
                  unit_opb   = WIDE_W'(s_mag);
               end
               P_X4B: begin
                  unit_steps = STEP_W'(B_W + 2);
                  unit_opa   = num_ff;
                  unit_opb   = WIDE_W'({b_ff, 2'b00});
               end
               P_DEN1: begin
                  unit_steps = STEP_W'(A_W);
                  unit_opa   = WIDE_W'(a_ff);
                  unit_opb   = WIDE_W'(a_ff - A_W'(1));
               end
               P_DEN2: begin
                  unit_steps = STEP_W'(N_W);
                  unit_opa   = den_ff;
                  unit_opb   = WIDE_W'(job_len_ff);
               end
               P_QUOT: begin
                  unit_cmd.op = bmse_pkg::OP_DIV;
                  unit_steps  = STEP_W'(WIDE_W);
                  unit_opa    = num_ff;
                  unit_opb    = den_ff;
               end
               P_ROOT: begin
                  unit_cmd.op = bmse_pkg::OP_SQRT;
                  unit_steps  = STEP_W'(bmse_pkg::ROOT_STEPS);
                  unit_opa    = WIDE_W'(num_ff[ROOT_W-1:0]);
               end
               default: begin
                  unit_cmd.start = 1'b0;
                  state_in       = S_IDLE;
               end
            endcase
         end

         S_CWAIT: begin
            if (!unit_busy) begin
               unique case (step_ff)
                  P_ISQRT_N: begin
                     b_in     = unit_result[B_W-1:0];
                     step_in  = P_DIV_NB;
                     state_in = S_CALC;
                  end
                  P_DIV_NB: begin
                     a_in = (unit_result > WIDE_W'(MAX_BATCHES)) ?
                            A_W'(MAX_BATCHES) : unit_result[A_W-1:0];
                     state_in = S_PROC;
                  end
                  P_BMEAN: begin
                     ram_wr_en = 1'b1;
                     bd_in     = bd_ff + A_W'(1);
                     acc_in    = '0;
                     wc_in     = '0;
                     state_in  = S_CHK;
                  end
                  P_SQUARE: begin
                     q_in   = q_ff + unit_result[Q_W-1:0];
                     idx_in = idx_ff + A_W'(1);
                     if ((idx_ff + A_W'(1)) == a_ff) begin
                        step_in  = P_MEAN;
                        state_in = S_CALC;
                     end else begin
                        state_in = S_FADDR;
                     end
                  end
                  P_MEAN: begin
                     mean_in  = ram_wr_data;
                     step_in  = P_AQ;
                     state_in = S_CALC;
                  end
                  P_AQ: begin
                     num_in   = unit_result;
                     step_in  = P_SS;
                     state_in = S_CALC;
                  end
                  P_SS: begin
                     num_in   = num_ff - unit_result;
                     step_in  = P_X4B;
                     state_in = S_CALC;
                  end
                  P_X4B: begin
                     num_in   = unit_result;
                     step_in  = P_DEN1;
                     state_in = S_CALC;
                  end
                  P_DEN1: begin
                     den_in   = unit_result;
                     step_in  = P_DEN2;
                     state_in = S_CALC;
                  end
                  P_DEN2: begin
                     den_in   = unit_result;
                     step_in  = P_QUOT;
                     state_in = S_CALC;
                  end
                  P_QUOT: begin
                     num_in = unit_result;
                     if (|unit_result[WIDE_W-1:ROOT_W]) begin
                        se_in    = bmse_pkg::SE_MAX;
                        state_in = S_EMIT;
                     end else begin
                        step_in  = P_ROOT;
                        state_in = S_CALC;
                     end
                  end
                  P_ROOT: begin
                     se_in    = se_round;
                     state_in = S_EMIT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = mean_ff;
               rsp_se_in    = se_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= P_ISQRT_N;
         seen_ff      <= '0;
         job_len_ff   <= '0;
         b_ff         <= '0;
         a_ff         <= '0;
         acc_ff       <= '0;
         wc_ff        <= '0;
         bd_ff        <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         seen_ff      <= seen_in;
         job_len_ff   <= job_len_in;
         b_ff         <= b_in;
         a_ff         <= a_in;
         acc_ff       <= acc_in;
         wc_ff        <= wc_in;
         bd_ff        <= bd_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      s_ff        <= s_in;
      q_ff        <= q_in;
      neg_ff      <= neg_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      mean_ff     <= mean_in;
      se_ff       <= se_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_se_ff   <= rsp_se_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_overall_mean   = rsp_mean_ff;
   assign rsp_standard_error = rsp_se_ff;

   bmse_unit #(
      .WIDE_W (WIDE_W)
   ) u_unit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (unit_cmd),
      .steps  (unit_steps),
      .opa    (unit_opa),
      .opb    (unit_opb),
      .busy   (unit_busy),
      .result (unit_result)
   );

   bmse_ram #(
      .WIDTH (X_W),
      .DEPTH (MAX_BATCHES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (bd_ff[IDX_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   `BMSE_ASSERT_HOLDS(a_unit_free, state_ff == S_CALC, !unit_busy)
   `BMSE_ASSERT_NEXT(a_unit_runs, state_ff == S_CALC && unit_cmd.start, unit_busy)
   `BMSE_ASSERT_HOLDS(a_store_in_range, ram_wr_en, bd_ff < a_ff)
   `BMSE_ASSERT_HOLDS(a_batch_open, state_ff == S_IDLE && seen_ff != '0, wc_ff < b_ff)
   `BMSE_ASSERT_HOLDS(a_seen_bound, state_ff == S_IDLE, seen_ff == '0 || seen_ff < job_len_ff)

endmodule

`default_nettype wire

[sv/bmse_ram.sv]
// Generic single-port-write, registered-read RAM.
`default_nettype none

module bmse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/bmse_unit.sv]
// Shared bit-serial unit: shift-add multiply, restoring divide, digit square root.
`default_nettype none

module bmse_unit #(
   parameter int WIDE_W = 94
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire bmse_pkg::unit_cmd_type       cmd,
   input  wire logic [$clog2(WIDE_W+1)-1:0]  steps,
   input  wire logic [WIDE_W-1:0]            opa,
   input  wire logic [WIDE_W-1:0]            opb,
   output logic                              busy,
   output logic      [WIDE_W-1:0]            result
);

   localparam int STEP_W = $clog2(WIDE_W+1);

   logic [WIDE_W-1:0]      p_ff, p_in;
   logic [WIDE_W-1:0]      m_ff, m_in;
   logic [WIDE_W-1:0]      d_ff, d_in;
   logic [WIDE_W-1:0]      rem_ff, rem_in;
   logic [STEP_W-1:0]      cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   bmse_pkg::unit_op_type  op_ff, op_in;

   logic [WIDE_W:0] r2;
   logic [WIDE_W:0] diff;
   logic [WIDE_W:0] root_try;

   always_comb begin
      r2       = {rem_ff, p_ff[WIDE_W-1]};
      diff     = r2 - {1'b0, d_ff};
      root_try = {1'b0, m_ff} + {1'b0, d_ff};

      p_in    = p_ff;
      m_in    = m_ff;
      d_in    = d_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      op_in   = op_ff;

      if (cmd.start) begin
         op_in   = cmd.op;
         cnt_in  = steps;
         busy_in = 1'b1;
         rem_in  = '0;
         unique case (cmd.op)
            bmse_pkg::OP_MUL: begin
               p_in = '0;
               m_in = opa;
               d_in = opb;
            end
            bmse_pkg::OP_DIV: begin
               p_in = opa;
               d_in = opb;
            end
            bmse_pkg::OP_SQRT: begin
               p_in = opa;
               m_in = '0;
               d_in = WIDE_W'(1) << (2*bmse_pkg::ROOT_STEPS - 2);
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            bmse_pkg::OP_MUL: begin
               if (d_ff[0]) begin
                  p_in = p_ff + m_ff;
               end
               m_in = m_ff << 1;
               d_in = d_ff >> 1;
            end
            bmse_pkg::OP_DIV: begin
               if (r2 >= {1'b0, d_ff}) begin
                  rem_in = diff[WIDE_W-1:0];
                  p_in   = {p_ff[WIDE_W-2:0], 1'b1};
               end else begin
                  rem_in = r2[WIDE_W-1:0];
                  p_in   = {p_ff[WIDE_W-2:0], 1'b0};
               end
            end
            bmse_pkg::OP_SQRT: begin
               if ({1'b0, p_ff} >= root_try) begin
                  p_in = p_ff - root_try[WIDE_W-1:0];
                  m_in = (m_ff >> 1) + d_ff;
               end else begin
                  m_in = m_ff >> 1;
               end
               d_in = d_ff >> 2;
            end
            default: begin
               p_in = p_ff;
            end
         endcase
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= bmse_pkg::OP_MUL;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      p_ff   <= p_in;
      m_ff   <= m_in;
      d_ff   <= d_in;
      rem_ff <= rem_in;
   end

   assign busy   = busy_ff;
   assign result = (op_ff == bmse_pkg::OP_SQRT) ? m_ff : p_ff;

endmodule

`default_nettype wire
